[rtl/core/stbs_pkg.sv]
package stbs_pkg;

  localparam int unsigned DefaultTableDepth = 1024;
  localparam int unsigned CountWidth        = 11;
  localparam int unsigned IndexWidth        = 10;
  localparam int unsigned ValueWidth        = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP
  } state_e;

  typedef struct packed {
    cmd_e                         command;
    logic [IndexWidth-1:0]        entry_index;
    logic signed [ValueWidth-1:0] entry_value;
    logic signed [ValueWidth-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [IndexWidth-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic load_we;
    logic init;
    logic issue;
    logic step;
    logic report_hit;
    logic report_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_nonempty;
    logic hit;
    logic next_nonempty;
  } dp_status_t;

endpackage

[rtl/core/sorted_table_binary_search.sv]
// channel  direction  handshake             payload
// item     in         start high, busy low  item_i (command, entry_index, entry_value, search_key)
// result   out        result_strobe_o       result_o (found, position)
// config   in         cfg_we_i              cfg_wdata_i (entry_count)
//
// a load item is written to the table while busy stays low
// a search item holds busy through a set-up state and then through its probes, at most
// floor(log2(count)) + 1 of them with count capped at the table depth, each a registered
// read of the table memory; the strobe comes as busy falls
// reset clears the entry count and control state; the table contents stay undefined
// the strobe is high for a single cycle and result_o holds until the next result; the receiver cannot stall it
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DefaultTableDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  stbs_pkg::in_item_t              item_i,
  output logic                            result_strobe_o,
  output stbs_pkg::out_item_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [stbs_pkg::CountWidth-1:0] cfg_wdata_i
);

  stbs_pkg::ctrl_cmd_t  cmd;
  stbs_pkg::dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .status_i  (status),
    .busy      (busy),
    .cmd_o     (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_i          (item_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

[rtl/core/stbs_ctrl.sv]
module stbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  stbs_pkg::cmd_e      command_i,
  input  stbs_pkg::dp_status_t status_i,
  output logic                busy,
  output stbs_pkg::ctrl_cmd_t cmd_o
);

  stbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (start && command_i == stbs_pkg::CMD_SEARCH) begin
          state_d = stbs_pkg::ST_ISSUE;
        end
      end
      stbs_pkg::ST_ISSUE: begin
        if (status_i.range_nonempty) begin
          state_d = stbs_pkg::ST_CMP;
        end else begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      stbs_pkg::ST_CMP: begin
        if (status_i.hit || !status_i.next_nonempty) begin
          state_d = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.load_we = start && command_i == stbs_pkg::CMD_LOAD;
        cmd_o.init    = start && command_i == stbs_pkg::CMD_SEARCH;
      end
      stbs_pkg::ST_ISSUE: begin
        cmd_o.issue       = status_i.range_nonempty;
        cmd_o.report_miss = !status_i.range_nonempty;
      end
      stbs_pkg::ST_CMP: begin
        cmd_o.report_hit  = status_i.hit;
        cmd_o.step        = !status_i.hit && status_i.next_nonempty;
        cmd_o.report_miss = !status_i.hit && !status_i.next_nonempty;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/stbs_datapath.sv]
module stbs_datapath #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DefaultTableDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stbs_pkg::CountWidth-1:0]      cfg_wdata_i,
  input  stbs_pkg::in_item_t                   item_i,
  input  stbs_pkg::ctrl_cmd_t                  cmd_i,
  output stbs_pkg::dp_status_t                 status_o,
  output logic                                 result_strobe_o,
  output stbs_pkg::out_item_t                  result_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic signed [stbs_pkg::ValueWidth-1:0] mem [TABLE_DEPTH];

  logic [stbs_pkg::CountWidth-1:0]        count_q;
  logic [CW-1:0]                          count_sat;
  logic [CW-1:0]                          low_q, low_d, hi1_q, hi1_d;
  logic [CW-1:0]                          next_low, next_hi1;
  logic [AW-1:0]                          mid_q, mid_cur, mid_next, rd_addr;
  logic signed [stbs_pkg::ValueWidth-1:0] key_q, rdata_q;
  logic                                   load_ok, key_below;
  logic                                   result_strobe_q;
  stbs_pkg::out_item_t                    result_q;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi1);
    logic [CW:0] sum;
    sum = (CW+1)'(lo) + (CW+1)'(hi1) - (CW+1)'(1);
    return AW'(sum >> 1);
  endfunction

  assign count_sat = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
  assign load_ok   = 32'(item_i.entry_index) < 32'(TABLE_DEPTH);

  assign key_below = key_q < rdata_q;
  assign next_low  = key_below ? low_q : CW'(mid_q) + CW'(1);
  assign next_hi1  = key_below ? CW'(mid_q) : hi1_q;
  assign mid_cur   = mid_of(low_q, hi1_q);
  assign mid_next  = mid_of(next_low, next_hi1);
  assign rd_addr   = cmd_i.step ? mid_next : mid_cur;

  assign status_o.range_nonempty = low_q < hi1_q;
  assign status_o.hit            = key_q == rdata_q;
  assign status_o.next_nonempty  = next_low < next_hi1;

  always_comb begin
    low_d = low_q;
    hi1_d = hi1_q;
    if (cmd_i.init) begin
      low_d = '0;
      hi1_d = count_sat;
    end else if (cmd_i.step) begin
      low_d = next_low;
      hi1_d = next_hi1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      result_strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      result_strobe_q <= cmd_i.report_hit || cmd_i.report_miss;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
    hi1_q <= hi1_d;
    if (cmd_i.init) begin
      key_q <= item_i.search_key;
    end
    if (cmd_i.issue || cmd_i.step) begin
      mid_q <= rd_addr;
    end
    if (cmd_i.report_hit) begin
      result_q.found    <= 1'b1;
      result_q.position <= stbs_pkg::IndexWidth'(mid_q);
    end else if (cmd_i.report_miss) begin
      result_q.found    <= 1'b0;
      result_q.position <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      mem[AW'(item_i.entry_index)] <= item_i.entry_value;
    end
    if (cmd_i.issue || cmd_i.step) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign result_strobe_o = result_strobe_q;
  assign result_o        = result_q;

endmodule

[tb/sorted_table_binary_search_tb.sv]
module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int unsigned Depth         = DefaultTableDepth;
  localparam int unsigned ItemGoal      = 1050;
  localparam int unsigned TailItems     = 150;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted    = 50;
  localparam int          IntMin        = 32'h8000_0000;
  localparam int          IntMax        = 32'h7FFF_FFFF;

  class search_scoreboard;
    int                    entries[Depth];
    bit                    written[Depth];
    logic [CountWidth-1:0] entry_count = '0;
    out_item_t             pending[$];
    int unsigned           n_errors;

    function int unsigned active_count();
      return (entry_count > Depth) ? Depth : entry_count;
    endfunction

    function int unsigned first_unwritten();
      for (int unsigned i = 0; i < Depth; i++) begin
        if (!written[i]) return i;
      end
      return Depth;
    endfunction

    function void set_count(logic [CountWidth-1:0] c);
      entry_count = c;
    endfunction

    function out_item_t search_table(int key);
      out_item_t res;
      int lo;
      int hi;
      int mid;
      res = '0;
      lo  = 0;
      hi  = int'(active_count()) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key < entries[mid]) begin
          hi = mid - 1;
        end else if (key > entries[mid]) begin
          lo = mid + 1;
        end else begin
          res.found    = 1'b1;
          res.position = mid[IndexWidth-1:0];
          break;
        end
      end
      return res;
    endfunction

    // an accepted item: loads update the shadow table, searches queue a result
    function void note_item(in_item_t it);
      if (it.command == CMD_LOAD) begin
        entries[it.entry_index] = it.entry_value;
        written[it.entry_index] = 1'b1;
      end else begin
        pending.push_back(search_table(it.search_key));
      end
    endfunction

    task report_mismatch(string what);
      n_errors++;
      if (n_errors <= MaxPrinted) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                  got.found, got.position));
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) begin
        report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
      end
      if (got.position !== want.position) begin
        report_mismatch($sformatf("position %0d, expected %0d",
                                  got.position, want.position));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_item_t              item;
  logic                  result_strobe;
  out_item_t             result;
  logic                  cfg_we;
  logic [CountWidth-1:0] cfg_wdata;

  search_scoreboard sb = new();
  int unsigned      n_items;
  int unsigned      quiet_cycles;
  bit               idle_en;
  bit               bulk;
  bit               full_done;

  sorted_table_binary_search u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item),
    .result_strobe_o (result_strobe),
    .result_o        (result),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe) sb.check_result(result);
      if (start && !busy) sb.note_item(item);
      if (cfg_we) sb.set_count(cfg_wdata);
      if ((start && !busy) || result_strobe || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic in_item_t make_load(int idx, int val);
    in_item_t it;
    it.command     = CMD_LOAD;
    it.entry_index = idx[IndexWidth-1:0];
    it.entry_value = val;
    it.search_key  = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_search(int key);
    in_item_t it;
    it.command     = CMD_SEARCH;
    it.entry_index = IndexWidth'($urandom);
    it.entry_value = $urandom;
    it.search_key  = key;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && n_items + TailItems < ItemGoal && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
    n_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountWidth-1:0] c);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_searches(input int unsigned m);
    int unsigned eff;
    int unsigned sel;
    int          key;
    for (int unsigned i = 0; i < m; i++) begin
      eff = sb.active_count();
      sel = $urandom_range(0, 11);
      key = $urandom;
      if (eff != 0 && sel <= 5) begin
        key = sb.entries[$urandom_range(0, eff - 1)];
      end else if (eff != 0 && sel <= 7) begin
        key = sb.entries[$urandom_range(0, eff - 1)] + ((sel == 6) ? 1 : -1);
      end else if (sel == 8) begin
        key = $urandom_range(0, 1) ? IntMin : IntMax;
      end
      if (eff != 0 && sel == 9) begin
        send_item(make_load($urandom_range(0, eff - 1), $urandom));
      end else begin
        send_item(make_search(key));
      end
    end
  endtask

  task automatic run_table_phase(input int unsigned n, input bit shuffled);
    int                    vals[$];
    int                    order[$];
    int                    base;
    int unsigned           mode;
    int unsigned           legal;
    logic [CountWidth-1:0] cnt;
    mode = $urandom_range(0, 2);
    base = $urandom;
    for (int unsigned i = 0; i < n; i++) begin
      order.push_back(i);
      case (mode)
        0: vals.push_back($urandom);
        1: vals.push_back(base + int'($urandom_range(0, 2 * n)));
        default: begin
          if ($urandom_range(0, 3) == 0) vals.push_back($urandom_range(0, 1) ? IntMin : IntMax);
          else vals.push_back($urandom);
        end
      endcase
    end
    vals.sort();
    if (shuffled) vals.shuffle();
    order.shuffle();
    bulk = (n == Depth);
    foreach (order[i]) begin
      if (!bulk && $urandom_range(0, 11) == 0) begin
        if (n < Depth && $urandom_range(0, 1)) begin
          send_item(make_load($urandom_range(n, Depth - 1), $urandom));
        end else begin
          send_item(make_search($urandom));
        end
      end
      send_item(make_load(order[i], vals[order[i]]));
    end
    bulk = 1'b0;
    wait_idle();
    legal = sb.first_unwritten();
    if (legal == Depth) legal = (1 << CountWidth) - 1;
    if ($urandom_range(0, 5) == 0) cnt = CountWidth'($urandom_range(0, legal));
    else cnt = CountWidth'(n);
    write_count(cnt);
    run_searches($urandom_range(4, 24));
  endtask

  task automatic run_directed();
    int vals[8] = '{IntMin, -1000, -1, 0, 1, 77, 1000, IntMax};
    // empty table right after reset
    send_item(make_search(IntMin));
    send_item(make_search(IntMax));
    for (int i = 0; i < 8; i++) send_item(make_load(i, vals[i]));
    wait_idle();
    write_count(CountWidth'(8));
    send_item(make_search(IntMin));
    send_item(make_search(IntMax));
    send_item(make_search(0));
    send_item(make_search(77));
    send_item(make_search(-999));
    send_item(make_search(-1));
    // break the ordering and search across it
    send_item(make_load(3, IntMax));
    send_item(make_search(77));
    send_item(make_search(0));
    wait_idle();
    write_count(CountWidth'(1));
    send_item(make_search(IntMin));
    send_item(make_search(5));
    wait_idle();
    write_count('0);
    send_item(make_search(0));
  endtask

  initial begin
    int unsigned n;
    rst_ni    = 1'b0;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_en   = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    while (n_items < ItemGoal) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if (!full_done) begin
        full_done = 1'b1;
        run_table_phase(Depth, 1'b0);
        wait_idle();
        write_count('1);
        run_searches(16);
        wait_idle();
        write_count(CountWidth'($urandom_range(Depth + 1, (1 << CountWidth) - 2)));
        run_searches(8);
        wait_idle();
        write_count(CountWidth'(Depth));
        run_searches(8);
        wait_idle();
        write_count(CountWidth'(Depth - 1));
        run_searches(8);
      end else begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          7, 8:    n = $urandom_range(17, 64);
          9:       n = $urandom_range(65, 100);
          default: n = $urandom_range(1, 16);
        endcase
        run_table_phase(n, $urandom_range(0, 7) == 0);
      end
    end

    wait_idle();
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/stbs_pkg.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_datapath.sv
rtl/core/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
